@@ rtl/cnmp_pkg.sv @@
// cnmp_pkg: shared types and constants for the circular non-adjacent max pick unit.
// Holds the transaction payload structs and the fixed field widths.
// No dependencies.
package cnmp_pkg;

	// fixed field widths
	localparam int SLICE_W = 16;
	localparam int SUM_W   = 24;

	// partial sums saturate here
	localparam logic [SUM_W-1:0] SUM_LIMIT = 24'hFF_FFFF;

	// input transaction
	typedef struct packed {
		logic [SLICE_W-1:0] slice_value;
		logic               last;
	} in_item_t;

	// result transaction
	typedef struct packed {
		logic [SUM_W-1:0] max_sum;
		logic             overflow;
	} result_t;

endpackage

@@ rtl/cnmp_ram.sv @@
// cnmp_ram: generic simple dual-port RAM, one write port, one registered read port.
// Width and depth are parameters. No dependencies.
module cnmp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cnmp_cell.sv @@
// cnmp_cell: the shared take-or-skip cell of the pick table.
// best = max(sat(value + prev_sum), skip_sum). Depends on cnmp_pkg.
module cnmp_cell #(
	parameter int VALUE_BITS = 16
) (
	input  logic [VALUE_BITS-1:0]      value,
	input  logic [cnmp_pkg::SUM_W-1:0] prev_sum,
	input  logic [cnmp_pkg::SUM_W-1:0] skip_sum,
	output logic [cnmp_pkg::SUM_W-1:0] best_sum
);
	import cnmp_pkg::*;

	localparam int TW = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;

	logic [TW-1:0]    take_wide;
	logic [SUM_W-1:0] take_sat;

	// take: add with saturation
	assign take_wide = TW'(value) + TW'(prev_sum);
	assign take_sat  = (take_wide > TW'(SUM_LIMIT)) ? SUM_LIMIT : take_wide[SUM_W-1:0];

	// keep the better of take and skip
	assign best_sum = (take_sat > skip_sum) ? take_sat : skip_sum;

endmodule

@@ rtl/circular_nonadjacent_max_pick_unit.sv @@
// circular_nonadjacent_max_pick_unit: top level, load sequencer and pick table sequencer.
// Depends on cnmp_pkg, cnmp_ram and cnmp_cell.
//
// Usage: elements are loaded one per transaction (start high while busy is low); busy stays
// low during loads. The transaction with last set closes the set of k elements. For k < 3
// the result strobe follows in the next cycle without busy. Otherwise busy is high while the
// table is filled and result_valid pulses in the first cycle with busy low again: one shared
// take-or-skip cell fills each table row at one element per cycle (k-1 cells plus a drain
// state per row), over floor(k/3) rows and two passes around the circle. The result is shown
// for a single cycle and cannot be stalled. Elements beyond MAX_ELEMENTS are dropped and
// reported through the overflow field of the result.
module circular_nonadjacent_max_pick_unit #(
	parameter int MAX_ELEMENTS = 512,
	parameter int VALUE_BITS   = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cnmp_pkg::in_item_t item,
	output logic               result_valid,
	output cnmp_pkg::result_t  result
);
	import cnmp_pkg::*;

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_ROW, S_DRAIN} state_t;

	state_t state_q;

	// load counters
	logic [CW-1:0] count_q;
	logic [1:0]    mod3_q;
	logic [CW-1:0] grp_q;
	logic          ovf_q;

	// pass control
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    npick_q;
	logic [CW-1:0]    row_q;
	logic [AW-1:0]    p_q;
	logic             pass_q;
	logic             ovf_res_q;
	logic [SUM_W-1:0] first_q;
	logic [SUM_W-1:0] skip_q;

	// cell pipeline stage
	logic          valid_s1;
	logic [AW-1:0] p_s1;
	logic          first_s1;
	logic          pzero_s1;

	// result register
	logic    res_valid_q;
	result_t res_q;

	// next-state of the load counters
	logic            accept;
	logic            store_ok;
	logic [CW-1:0]   count_nx;
	logic [1:0]      mod3_nx;
	logic [CW-1:0]   grp_nx;
	logic            ovf_nx;
	logic [VALUE_BITS-1:0] in_val;

	// datapath
	logic [AW-1:0]         plast;
	logic [AW-1:0]         val_raddr;
	logic [AW-1:0]         prev_raddr;
	logic [VALUE_BITS-1:0] val_rdata;
	logic [SUM_W-1:0]      row_a_rdata;
	logic [SUM_W-1:0]      row_b_rdata;
	logic [SUM_W-1:0]      prev_sum;
	logic [SUM_W-1:0]      skip_sum;
	logic [SUM_W-1:0]      best_sum;

	// only the low VALUE_BITS of the slice value, zero-extended when VALUE_BITS exceeds SLICE_W
	generate
		if (VALUE_BITS <= SLICE_W) begin : g_val_narrow
			assign in_val = item.slice_value[VALUE_BITS-1:0];
		end else begin : g_val_wide
			assign in_val = {{(VALUE_BITS - SLICE_W){1'b0}}, item.slice_value};
		end
	endgenerate

	// load bookkeeping; picks counted in groups of three so no divider is needed
	assign accept   = start && (state_q == S_IDLE);
	assign store_ok = (count_q != CW'(MAX_ELEMENTS));
	assign count_nx = store_ok ? count_q + CW'(1) : count_q;
	assign mod3_nx  = !store_ok ? mod3_q : ((mod3_q == 2'd2) ? 2'd0 : mod3_q + 2'd1);
	assign grp_nx   = (store_ok && (mod3_q == 2'd2)) ? grp_q + CW'(1) : grp_q;
	assign ovf_nx   = ovf_q | ~store_ok;

	// row addressing: p runs from len-1 down to 0
	assign plast      = AW'(len_q - CW'(1));
	assign val_raddr  = p_q + AW'(pass_q);
	assign prev_raddr = p_q + AW'(2);

	// element store
	cnmp_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (MAX_ELEMENTS)
	) u_value_store (
		.clk   (clk),
		.we    (accept && store_ok),
		.waddr (AW'(count_q)),
		.wdata (in_val),
		.raddr (val_raddr),
		.rdata (val_rdata)
	);

	// two table rows, ping-ponged: odd rows write A, even rows write B
	cnmp_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_ELEMENTS)
	) u_row_a (
		.clk   (clk),
		.we    (valid_s1 && row_q[0]),
		.waddr (p_s1),
		.wdata (best_sum),
		.raddr (prev_raddr),
		.rdata (row_a_rdata)
	);

	cnmp_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_ELEMENTS)
	) u_row_b (
		.clk   (clk),
		.we    (valid_s1 && !row_q[0]),
		.waddr (p_s1),
		.wdata (best_sum),
		.raddr (prev_raddr),
		.rdata (row_b_rdata)
	);

	// cell operands: first row and out-of-range entries read as zero
	assign prev_sum = pzero_s1 ? '0 : (row_q[0] ? row_b_rdata : row_a_rdata);
	assign skip_sum = first_s1 ? '0 : skip_q;

	cnmp_cell #(
		.VALUE_BITS (VALUE_BITS)
	) u_cell (
		.value    (val_rdata),
		.prev_sum (prev_sum),
		.skip_sum (skip_sum),
		.best_sum (best_sum)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			mod3_q      <= '0;
			grp_q       <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			npick_q     <= '0;
			row_q       <= '0;
			p_q         <= '0;
			pass_q      <= 1'b0;
			ovf_res_q   <= 1'b0;
			first_q     <= '0;
			skip_q      <= '0;
			valid_s1    <= 1'b0;
			p_s1        <= '0;
			first_s1    <= 1'b0;
			pzero_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (valid_s1) begin
				skip_q <= best_sum;
			end
			case (state_q)
				S_IDLE: begin
					valid_s1 <= 1'b0;
					if (accept) begin
						if (item.last) begin
							count_q   <= '0;
							mod3_q    <= '0;
							grp_q     <= '0;
							ovf_q     <= 1'b0;
							len_q     <= count_nx - CW'(1);
							npick_q   <= grp_nx;
							ovf_res_q <= ovf_nx;
							pass_q    <= 1'b0;
							row_q     <= CW'(1);
							p_q       <= AW'(count_nx - CW'(2));
							if (grp_nx == '0) begin
								// fewer than three elements
								res_q.max_sum  <= '0;
								res_q.overflow <= ovf_nx;
								res_valid_q    <= 1'b1;
							end else begin
								state_q <= S_ROW;
							end
						end else begin
							count_q <= count_nx;
							mod3_q  <= mod3_nx;
							grp_q   <= grp_nx;
							ovf_q   <= ovf_nx;
						end
					end
				end
				S_ROW: begin
					// issue one cell per cycle
					valid_s1 <= 1'b1;
					p_s1     <= p_q;
					first_s1 <= (p_q == plast);
					pzero_s1 <= (row_q == CW'(1)) ||
						((CW'(p_q) + CW'(2)) >= len_q);
					if (p_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						p_q <= p_q - AW'(1);
					end
				end
				S_DRAIN: begin
					// cell for position 0 completes here
					valid_s1 <= 1'b0;
					p_q      <= plast;
					if (row_q == npick_q) begin
						row_q <= CW'(1);
						if (!pass_q) begin
							first_q <= best_sum;
							pass_q  <= 1'b1;
							state_q <= S_ROW;
						end else begin
							res_q.max_sum  <= (first_q > best_sum) ? first_q : best_sum;
							res_q.overflow <= ovf_res_q;
							res_valid_q    <= 1'b1;
							state_q        <= S_IDLE;
						end
					end else begin
						row_q   <= row_q + CW'(1);
						state_q <= S_ROW;
					end
				end
				default: begin
					valid_s1 <= 1'b0;
					state_q  <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking testbench for circular_nonadjacent_max_pick_unit.
// Walks a directed table, random sets of slices and one set past capacity; each result is
// checked against a pick-table predictor or hand-typed sum. Depends on cnmp_pkg, unit RTL.
module tb_top;
	import cnmp_pkg::*;

	localparam int CAPACITY    = 512;
	localparam int VALUE_BITS  = 16;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_SLICES = 420;

	// one row of the directed table; has_sum marks a hand-typed expectation
	typedef struct {
		logic [SLICE_W-1:0] value;
		bit                 last;
		bit                 has_sum;
		logic [SUM_W-1:0]   sum;
		bit                 ovf;
	} stim_row_t;

	localparam int DIR_ROWS = 21;

	stim_row_t dir_rows [0:DIR_ROWS-1] = '{
		// single slice straight after reset: no picks
		'{16'hFFFF, 1'b1, 1'b1, 24'd0, 1'b0},
		// two slices: still no picks
		'{16'h1234, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'hFFFF, 1'b1, 1'b1, 24'd0, 1'b0},
		// three slices, one pick: the largest value
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0002, 1'b1, 1'b1, 24'h00FFFF, 1'b0},
		// three zeros
		'{16'h0000, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0000, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0000, 1'b1, 1'b1, 24'd0, 1'b0},
		// six slices, mixed extremes
		'{16'h8000, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h7FFF, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'hFFFF, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0000, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'hAAAA, 1'b1, 1'b0, 24'd0, 1'b0},
		// first and last slice are neighbours: both big ones cannot be taken
		'{16'h0064, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0001, 1'b0, 1'b0, 24'd0, 1'b0},
		'{16'h0064, 1'b1, 1'b1, 24'h000065, 1'b0}
	};

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	in_item_t item;
	logic     result_valid;
	result_t  result;

	circular_nonadjacent_max_pick_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result)
	);

	// predictor state
	int unsigned slice_mem [0:CAPACITY-1];
	int unsigned fill_count;
	bit          dropped_seen;

	result_t expected_results [$];
	int      fail_count;
	int      results_checked;
	int      sets_closed;
	int      overflow_sets;
	int      slices_sent;
	int      cycle_count;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// best sum of picks non-adjacent slices from slice_mem[lo .. lo+len-1], filled bottom-up
	function automatic longint unsigned linear_best(int unsigned lo, int unsigned len,
			int unsigned picks);
		longint unsigned prev_row [0:CAPACITY+1];
		longint unsigned cur_row [0:CAPACITY+1];
		longint unsigned take_sum;
		longint unsigned skip_sum;
		int p;

		if (picks == 0 || len == 0 || len > CAPACITY || lo + len > CAPACITY)
			return 0;
		for (p = 0; p < len + 2; p++)
			prev_row[p] = 0;
		for (int m = 1; m <= picks; m++) begin
			cur_row[len]     = 0;
			cur_row[len + 1] = 0;
			for (p = len - 1; p >= 0; p--) begin
				take_sum = longint'(slice_mem[lo + p]) + prev_row[p + 2];
				if (take_sum > longint'(SUM_LIMIT))
					take_sum = longint'(SUM_LIMIT);
				skip_sum = cur_row[p + 1];
				cur_row[p] = (take_sum > skip_sum) ? take_sum : skip_sum;
			end
			for (p = 0; p < len + 2; p++)
				prev_row[p] = cur_row[p];
		end
		return prev_row[0];
	endfunction

	// fold one accepted slice into the predictor; closes the set on last
	task automatic absorb_slice(input in_item_t it, output bit produced,
			output result_t predicted);
		int unsigned k;
		int unsigned picks;
		longint unsigned first_best;
		longint unsigned second_best;
		longint unsigned best;

		produced  = 1'b0;
		predicted = '0;
		if (fill_count < CAPACITY) begin
			slice_mem[fill_count] = it.slice_value & ((1 << VALUE_BITS) - 1);
			fill_count++;
		end else begin
			dropped_seen = 1'b1;
		end
		if (!it.last)
			return;
		k     = fill_count;
		picks = k / 3;
		if (picks == 0 || k < 2) begin
			first_best  = 0;
			second_best = 0;
		end else begin
			first_best  = linear_best(0, k - 1, picks);
			second_best = linear_best(1, k - 1, picks);
		end
		best = (first_best > second_best) ? first_best : second_best;
		if (best > longint'(SUM_LIMIT))
			best = longint'(SUM_LIMIT);
		predicted.max_sum  = best[SUM_W-1:0];
		predicted.overflow = dropped_seen;
		produced = 1'b1;
		sets_closed++;
		if (dropped_seen)
			overflow_sets++;
		fill_count   = 0;
		dropped_seen = 1'b0;
	endtask

	// present one slice until accepted
	task automatic send_slice(input in_item_t it, output bit produced,
			output result_t predicted);
		start <= 1'b1;
		item  <= it;
		do
			@(posedge clk);
		while (busy);
		slices_sent++;
		absorb_slice(it, produced, predicted);
	endtask

	// drop start and idle for the requested gap after an accepted slice
	task automatic idle_gap(input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random slice value: extremes, small values for ties, or full range
	function automatic logic [SLICE_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return SLICE_W'($urandom_range(0, 15));
			default: return SLICE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// result checker: every strobe must match the oldest expectation
	always @(posedge clk) begin
		result_t want;

		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: max_sum=%0d overflow=%0b",
					$time, result.max_sum, result.overflow);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (result.max_sum !== want.max_sum) begin
					$display("%0t: max_sum mismatch: expected %0d, actual %0d",
						$time, want.max_sum, result.max_sum);
					fail_count++;
				end
				if (result.overflow !== want.overflow) begin
					$display("%0t: overflow mismatch: expected %0b, actual %0b",
						$time, want.overflow, result.overflow);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_results.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		bit       produced;
		result_t  predicted;
		int       set_size;
		int       random_slices;
		bit       burst;
		int       gap;

		fail_count      = 0;
		results_checked = 0;
		sets_closed     = 0;
		overflow_sets   = 0;
		slices_sent     = 0;
		cycle_count     = 0;
		fill_count      = 0;
		dropped_seen    = 1'b0;
		random_slices   = 0;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			it.slice_value = dir_rows[r].value;
			it.last        = dir_rows[r].last;
			send_slice(it, produced, predicted);
			if (produced) begin
				if (dir_rows[r].has_sum) begin
					predicted.max_sum  = dir_rows[r].sum;
					predicted.overflow = dir_rows[r].ovf;
				end
				expected_results.push_back(predicted);
			end
			idle_gap($urandom_range(0, 5));
		end

		// random sets, mostly small
		while (random_slices < RANDOM_SLICES) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: set_size = $urandom_range(1, 2);
				4, 5, 6, 7, 8, 9, 10, 11, 12, 13: set_size = $urandom_range(3, 15);
				14, 15, 16, 17, 18: set_size = $urandom_range(16, 40);
				default: set_size = $urandom_range(41, 80);
			endcase
			burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < set_size; i++) begin
				it.slice_value = draw_value();
				it.last        = (i == set_size - 1);
				gap = burst ? 0 : $urandom_range(0, 5);
				send_slice(it, produced, predicted);
				if (produced)
					expected_results.push_back(predicted);
				idle_gap(gap);
			end
			random_slices += set_size;
		end

		// one full set past capacity: two extras dropped, the last one among them
		for (int i = 0; i < CAPACITY + 2; i++) begin
			it.slice_value = (i < CAPACITY) ? 16'hFFFF : draw_value();
			it.last        = (i == CAPACITY + 1);
			gap = (i == CAPACITY + 1) ? 1 : $urandom_range(0, 5);
			send_slice(it, produced, predicted);
			if (produced)
				expected_results.push_back(predicted);
			idle_gap(gap);
		end

		// drain
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Loaded %0d slices in %0d sets, %0d of them past capacity.",
			slices_sent, sets_closed, overflow_sets);
		$display("Compared %0d results, %0d mismatches.", results_checked, fail_count);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
